### src/hmnt_pkg.sv
package hmnt_pkg;

  localparam int MAX_TEMPLATES = 64;
  localparam int HU_ORDER      = 7;
  localparam int FRAC_BITS     = 16;

  localparam int LOG_W   = 26;
  localparam int DIST_W  = 27;
  localparam int CLS_W   = 16;
  localparam int HELD_W  = 7;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;
  localparam int DBL_W   = 64;
  localparam int TPL_AW  = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
  localparam int CNT_W   = $clog2(MAX_TEMPLATES + 1);
  localparam int DIFF_W  = LOG_W + 1;
  localparam int SQ_W    = 2 * LOG_W;
  localparam int SUM_W   = SQ_W + 3;
  localparam int ROOT_W  = SUM_W + 1;
  localparam int ROW_W   = CLS_W + HU_ORDER * LOG_W;
  localparam int THR_SQ_W = 2 * DIST_W;

  localparam logic [LOG_W-1:0]  LOG_MAX  = LOG_W'((64'd1 << (LOG_W - 1)) - 64'd1);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [30:0]       LOG10_2_Q32 = 31'd1292913986;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_MATCHED  = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_APPENDED = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic              capture;
    logic              log_start;
    logic              wr_en;
    logic              rd_en;
    logic              rd_first;
    logic [TPL_AW-1:0] addr;
    logic              sqrt_start;
  } hmnt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic log_busy;
    logic pipe_busy;
    logic sqrt_busy;
    logic unknown;
  } hmnt_sts_t;

endpackage

### src/hmnt_ram.sv
module hmnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/hmnt_log.sv
module hmnt_log (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [hmnt_pkg::DBL_W-1:0]         bits_i,
  output logic                               busy_o,
  output logic signed [hmnt_pkg::LOG_W-1:0]  val_o
);
  import hmnt_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_MUL, L_FIN} lstate_e;

  localparam int RND_SH = 32 - FRAC_BITS;
  localparam logic [43:0] RND_ADD = 44'd1 << (RND_SH - 1);

  lstate_e            state_q;
  logic [52:0]        sig_q;
  logic signed [11:0] exp_q;
  logic [31:0]        y_q;
  logic [31:0]        f_q;
  logic [4:0]         cnt_q;
  logic               hneg_q;
  logic               lneg_q;
  logic [41:0]        phi_q;
  logic [62:0]        plo_q;
  logic [LOG_W-1:0]   val_q;

  logic [10:0]  ex;
  logic [51:0]  fr;
  logic [63:0]  sq;
  logic [43:0]  v;
  logic [43:0]  mag;
  logic [43:0]  rsum;
  logic [43:0]  rsh;
  logic [LOG_W-1:0] rmag;

  always_comb begin
    ex   = bits_i[62:52];
    fr   = bits_i[51:0];
    sq   = y_q * y_q;
    v    = {exp_q, f_q};
    mag  = v[43] ? (44'd0 - v) : v;
    rsum = 44'(phi_q) + 44'(plo_q[62:32]) + RND_ADD;
    rsh  = rsum >> RND_SH;
    rmag = (rsh > 44'(LOG_MAX)) ? LOG_MAX : rsh[LOG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            hneg_q <= bits_i[63];
            if (ex == '1) begin
              // Infinity saturates, NaN maps to zero.
              if (fr != '0) begin
                val_q <= '0;
              end else begin
                val_q <= bits_i[63] ? (LOG_W'(0) - LOG_MAX) : LOG_MAX;
              end
            end else if (ex == '0) begin
              if (fr == '0) begin
                val_q <= '0;
              end else begin
                sig_q   <= {1'b0, fr};
                exp_q   <= -12'sd1022;
                state_q <= L_NORM;
              end
            end else begin
              y_q     <= {1'b1, fr[51:21]};
              exp_q   <= $signed({1'b0, ex}) - 12'sd1023;
              f_q     <= '0;
              cnt_q   <= '0;
              state_q <= L_SQ;
            end
          end
        end
        L_NORM: begin
          if (sig_q[52]) begin
            y_q     <= sig_q[52:21];
            f_q     <= '0;
            cnt_q   <= '0;
            state_q <= L_SQ;
          end else begin
            sig_q <= {sig_q[51:0], 1'b0};
            exp_q <= exp_q - 12'sd1;
          end
        end
        L_SQ: begin
          // One fraction bit of log2 per squaring.
          if (sq[63]) begin
            y_q <= sq[63:32];
            f_q <= {f_q[30:0], 1'b1};
          end else begin
            y_q <= sq[62:31];
            f_q <= {f_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= L_MUL;
          end
        end
        L_MUL: begin
          lneg_q  <= v[43];
          phi_q   <= mag[42:32] * LOG10_2_Q32;
          plo_q   <= mag[31:0] * LOG10_2_Q32;
          state_q <= L_FIN;
        end
        L_FIN: begin
          val_q   <= (hneg_q ^ lneg_q) ? (LOG_W'(0) - rmag) : rmag;
          state_q <= L_IDLE;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != L_IDLE);
  assign val_o  = $signed(val_q);

endmodule

### src/hmnt_dp.sv
module hmnt_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  hmnt_pkg::hmnt_cmd_t                    cmd_i,
  output hmnt_pkg::hmnt_sts_t                    sts_o,
  input  logic [hmnt_pkg::HU_ORDER-1:0][hmnt_pkg::DBL_W-1:0] hu_i,
  input  logic [hmnt_pkg::CLS_W-1:0]             class_id_i,
  input  logic [hmnt_pkg::DIST_W-1:0]            thr_i,
  output logic [hmnt_pkg::CLS_W-1:0]             cls_o,
  output logic [hmnt_pkg::DIST_W-1:0]            dist_o
);
  import hmnt_pkg::*;

  localparam int ROOT_TOP = ((SUM_W - 1) / 2) * 2;

  logic [HU_ORDER-1:0]             lane_busy;
  logic signed [LOG_W-1:0]         lane_val [HU_ORDER];
  logic [CLS_W-1:0]                class_q;
  logic [ROW_W-1:0]                row_wdata;
  logic [ROW_W-1:0]                row_rdata;

  logic                            v1_q, v2_q, v3_q, v4_q;
  logic                            f1_q, f2_q, f3_q, f4_q;
  logic [CLS_W-1:0]                cls2_q, cls3_q, cls4_q, best_cls_q;
  logic signed [DIFF_W-1:0]        diff [HU_ORDER];
  logic [DIFF_W-1:0]               absd [HU_ORDER];
  logic [SQ_W-1:0]                 sq_d [HU_ORDER];
  logic [SQ_W-1:0]                 sq_q [HU_ORDER];
  logic [SUM_W-1:0]                p_q [4];
  logic [SUM_W-1:0]                sum_q;
  logic [SUM_W-1:0]                best_q;

  logic [SUM_W-1:0]                rx_q;
  logic [ROOT_W-1:0]               rres_q;
  logic [ROOT_W-1:0]               rbit_q;
  logic [ROOT_W-1:0]               rtry;
  logic [THR_SQ_W-1:0]             thr_sq_q;

  for (genvar j = 0; j < HU_ORDER; j++) begin : g_lane
    hmnt_log u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cmd_i.log_start),
      .bits_i  (hu_i[j]),
      .busy_o  (lane_busy[j]),
      .val_o   (lane_val[j])
    );
    assign row_wdata[j*LOG_W +: LOG_W] = lane_val[j];
  end

  assign row_wdata[ROW_W-1 -: CLS_W] = class_q;

  // One row per template: class id on top, seven log values below.
  hmnt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_TEMPLATES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.addr),
    .wdata_i (row_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.addr),
    .rdata_o (row_rdata)
  );

  always_comb begin
    for (int j = 0; j < HU_ORDER; j++) begin
      diff[j] = DIFF_W'(lane_val[j]) -
                DIFF_W'($signed(row_rdata[j*LOG_W +: LOG_W]));
      absd[j] = diff[j][DIFF_W-1] ? (DIFF_W'(0) - diff[j]) : diff[j];
      sq_d[j] = SQ_W'(absd[j][LOG_W-1:0]) * SQ_W'(absd[j][LOG_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      class_q <= class_id_i;
    end
    f1_q   <= cmd_i.rd_first;
    f2_q   <= f1_q;
    f3_q   <= f2_q;
    f4_q   <= f3_q;
    cls2_q <= row_rdata[ROW_W-1 -: CLS_W];
    cls3_q <= cls2_q;
    cls4_q <= cls3_q;
    for (int j = 0; j < HU_ORDER; j++) begin
      sq_q[j] <= sq_d[j];
    end
    p_q[0] <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]);
    p_q[1] <= SUM_W'(sq_q[2]) + SUM_W'(sq_q[3]);
    p_q[2] <= SUM_W'(sq_q[4]) + SUM_W'(sq_q[5]);
    p_q[3] <= SUM_W'(sq_q[6]);
    sum_q  <= p_q[0] + p_q[1] + p_q[2] + p_q[3];
    // The first template seeds the minimum; later ones must be strictly less.
    if (v4_q && (f4_q || (sum_q < best_q))) begin
      best_q     <= sum_q;
      best_cls_q <= cls4_q;
    end
  end

  // Integer square root, one result bit per cycle.
  assign rtry = rres_q + rbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbit_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      rbit_q <= ROOT_W'(1) << ROOT_TOP;
    end else if (rbit_q != '0) begin
      rbit_q <= rbit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rx_q     <= best_q;
      rres_q   <= '0;
      thr_sq_q <= THR_SQ_W'(thr_i) * THR_SQ_W'(thr_i);
    end else if (rbit_q != '0) begin
      if (ROOT_W'(rx_q) >= rtry) begin
        rx_q   <= rx_q - rtry[SUM_W-1:0];
        rres_q <= (rres_q >> 1) + rbit_q;
      end else begin
        rres_q <= rres_q >> 1;
      end
    end
  end

  assign sts_o.log_busy  = |lane_busy;
  assign sts_o.pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign sts_o.sqrt_busy = (rbit_q != '0);
  assign sts_o.unknown   = (best_q > SUM_W'(thr_sq_q));

  assign cls_o  = best_cls_q;
  assign dist_o = (rres_q > ROOT_W'(DIST_MAX)) ? DIST_MAX : rres_q[DIST_W-1:0];

endmodule

### src/hmnt_ctrl.sv
module hmnt_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hmnt_pkg::KIND_W-1:0]   kind_i,
  input  logic                          out_free_i,
  input  hmnt_pkg::hmnt_sts_t           sts_i,
  output hmnt_pkg::hmnt_cmd_t           cmd_o,
  output logic                          res_valid_o,
  output hmnt_pkg::status_e             res_status_o,
  output logic                          res_query_o,
  output logic [hmnt_pkg::CNT_W-1:0]    total_o
);
  import hmnt_pkg::*;

  typedef enum logic [2:0] {C_IDLE, C_LOG, C_SCAN, C_DRAIN, C_SQRT, C_RESULT} cstate_e;

  cstate_e           state_q;
  logic [KIND_W-1:0] kind_q;
  logic [CNT_W-1:0]  total_q;
  logic [TPL_AW-1:0] addr_q;
  status_e           status_q;
  logic              query_q;
  logic              accept;
  logic              has_room;
  logic              last_addr;

  assign accept    = in_valid_i && (state_q == C_IDLE);
  assign has_room  = (total_q < CNT_W'(MAX_TEMPLATES));
  assign last_addr = ((CNT_W'(addr_q) + CNT_W'(1)) == total_q);

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = accept;
    cmd_o.log_start  = accept;
    cmd_o.addr       = (state_q == C_LOG) ? total_q[TPL_AW-1:0] : addr_q;
    cmd_o.wr_en      = (state_q == C_LOG) && !sts_i.log_busy &&
                       (kind_q == KIND_APPEND) && has_room;
    cmd_o.rd_en      = (state_q == C_SCAN);
    cmd_o.rd_first   = (addr_q == '0);
    cmd_o.sqrt_start = (state_q == C_DRAIN) && !sts_i.pipe_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      kind_q   <= KIND_CLEAR;
      total_q  <= '0;
      addr_q   <= '0;
      status_q <= ST_CLEARED;
      query_q  <= 1'b0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (accept) begin
            kind_q  <= kind_i;
            state_q <= C_LOG;
          end
        end
        C_LOG: begin
          if (!sts_i.log_busy) begin
            query_q <= 1'b0;
            if (kind_q == KIND_CLEAR) begin
              total_q  <= '0;
              status_q <= ST_CLEARED;
              state_q  <= C_RESULT;
            end else if (kind_q == KIND_APPEND) begin
              if (has_room) begin
                total_q  <= total_q + CNT_W'(1);
                status_q <= ST_APPENDED;
              end else begin
                status_q <= ST_FULL;
              end
              state_q <= C_RESULT;
            end else if (total_q == '0) begin
              status_q <= ST_EMPTY;
              state_q  <= C_RESULT;
            end else begin
              addr_q  <= '0;
              state_q <= C_SCAN;
            end
          end
        end
        C_SCAN: begin
          if (last_addr) begin
            state_q <= C_DRAIN;
          end else begin
            addr_q <= addr_q + TPL_AW'(1);
          end
        end
        C_DRAIN: begin
          if (!sts_i.pipe_busy) begin
            state_q <= C_SQRT;
          end
        end
        C_SQRT: begin
          if (!sts_i.sqrt_busy) begin
            status_q <= sts_i.unknown ? ST_UNKNOWN : ST_MATCHED;
            query_q  <= 1'b1;
            state_q  <= C_RESULT;
          end
        end
        C_RESULT: begin
          if (out_free_i) begin
            state_q <= C_IDLE;
          end
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != C_IDLE);
  assign res_valid_o  = (state_q == C_RESULT);
  assign res_status_o = status_q;
  assign res_query_o  = query_q;
  assign total_o      = total_q;

endmodule

### src/hu_moment_nearest_template.sv
// Clear and append wait for the seven log lanes, which finish at once when every
// moment is zero, infinity or NaN and take longer when a moment is subnormal.
// A query then scans the N templates and takes the square root.
// Throughput: one item at a time; the next item can be taken in the cycle
// after the result is handed to the output register. Reset is asynchronous,
// active low, empties the table and loads the threshold with 19661.
module hu_moment_nearest_template
  import hmnt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [CLS_W-1:0]     class_id_i,
  input  logic [DBL_W-1:0]     hu_0_i,
  input  logic [DBL_W-1:0]     hu_1_i,
  input  logic [DBL_W-1:0]     hu_2_i,
  input  logic [DBL_W-1:0]     hu_3_i,
  input  logic [DBL_W-1:0]     hu_4_i,
  input  logic [DBL_W-1:0]     hu_5_i,
  input  logic [DBL_W-1:0]     hu_6_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STAT_W-1:0]    status_o,
  output logic [CLS_W-1:0]     match_class_o,
  output logic [DIST_W-1:0]    match_distance_o,
  output logic [HELD_W-1:0]    templates_held_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // The only register, the distance threshold, lives at word index zero.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic [DIST_W-1:0] THR_RESET = DIST_W'(19661);

  logic [DIST_W-1:0]                 thr_q;
  logic [HU_ORDER-1:0][DBL_W-1:0]    hu;
  hmnt_cmd_t                         cmd;
  hmnt_sts_t                         sts;
  logic                              res_valid;
  status_e                           res_status;
  logic                              res_query;
  logic [CNT_W-1:0]                  total;
  logic [CLS_W-1:0]                  dp_cls;
  logic [DIST_W-1:0]                 dp_dist;
  logic                              out_free;
  logic                              load;

  logic                              out_valid_q;
  logic [STAT_W-1:0]                 status_q;
  logic [CLS_W-1:0]                  class_q;
  logic [DIST_W-1:0]                 dist_q;
  logic [HELD_W-1:0]                 held_q;

  assign hu = {hu_6_i, hu_5_i, hu_4_i, hu_3_i, hu_2_i, hu_1_i, hu_0_i};

  // Configuration port. Writes complete in the access phase with no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thr_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      thr_q <= pwdata[DIST_W-1:0];
    end
  end

  // The controller sequences log conversion, the template scan and the square
  // root; the datapath holds the lanes, the template memory and the arithmetic.
  hmnt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .out_free_i   (out_free),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .res_valid_o  (res_valid),
    .res_status_o (res_status),
    .res_query_o  (res_query),
    .total_o      (total)
  );

  hmnt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .hu_i       (hu),
    .class_id_i (class_id_i),
    .thr_i      (thr_q),
    .cls_o      (dp_cls),
    .dist_o     (dp_dist)
  );

  // Output register: a finished item waits here while the core takes the next.
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = res_valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Class and distance are only meaningful for a query that saw templates.
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= res_status;
      class_q  <= res_query ? dp_cls : '0;
      dist_q   <= res_query ? dp_dist : '0;
      held_q   <= HELD_W'(total);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign match_class_o    = class_q;
  assign match_distance_o = dist_q;
  assign templates_held_o = held_q;

endmodule

### src/hmnt_checker.sv
module hmnt_checker
  import hmnt_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [KIND_W-1:0]    kind_i,
  input logic [CLS_W-1:0]     class_id_i,
  input logic [DBL_W-1:0]     hu_0_i,
  input logic [DBL_W-1:0]     hu_1_i,
  input logic [DBL_W-1:0]     hu_2_i,
  input logic [DBL_W-1:0]     hu_3_i,
  input logic [DBL_W-1:0]     hu_4_i,
  input logic [DBL_W-1:0]     hu_5_i,
  input logic [DBL_W-1:0]     hu_6_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [STAT_W-1:0]    status_o,
  input logic [CLS_W-1:0]     match_class_o,
  input logic [DIST_W-1:0]    match_distance_o,
  input logic [HELD_W-1:0]    templates_held_o,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [2:0]           paddr,
  input logic [31:0]          pwdata,
  input logic [31:0]          prdata,
  input logic                 pready
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(match_class_o) && $stable(match_distance_o) && $stable(templates_held_o))
    else $error("stalled result changed");

  // A clear leaves the table empty.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CLEARED) |-> templates_held_o == '0)
    else $error("clear reported templates held");

  // A full answer only comes with a full table.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> templates_held_o == HELD_W'(MAX_TEMPLATES))
    else $error("full reported with room left");

  // Non-query results carry no class or distance.
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY || status_o == ST_APPENDED ||
    status_o == ST_FULL || status_o == ST_CLEARED) |->
    match_class_o == '0 && match_distance_o == '0)
    else $error("class or distance set on a non-match result");

  // A query with templates present never reports an empty table.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_MATCHED || status_o == ST_UNKNOWN) |->
    templates_held_o != '0)
    else $error("match reported with no templates");

endmodule

bind hu_moment_nearest_template hmnt_checker u_hmnt_checker (.*);

### bench/hu_moment_nearest_template_tb.sv
`timescale 1ns / 100ps

module hu_moment_nearest_template_tb;
  import hmnt_pkg::*;

  // Item kinds beyond the two that the package names. Kind 3 is unused and
  // the block treats it as a query, so it is driven on purpose now and then.
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Register map: the threshold at index 0, and an address with no register.
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_NONE      = 3'd4;

  localparam logic [DIST_W-1:0] THR_RESET = 27'd19661;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 600;

  // A handful of doubles that sit on the edges of the log conversion.
  localparam logic [63:0] D_POS_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [63:0] D_NEG_ZERO = 64'h8000_0000_0000_0000;
  localparam logic [63:0] D_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] D_NEG_ONE  = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] D_POS_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] D_NEG_INF  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] D_NAN      = 64'h7FF8_0000_0000_0001;
  localparam logic [63:0] D_MAX      = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] D_SUB_MIN  = 64'h0000_0000_0000_0001;
  localparam logic [63:0] D_SUB_MAX  = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] D_NEG_NORM = 64'h8010_0000_0000_0000;
  localparam logic [63:0] D_TENTH    = 64'h3FB9_9999_9999_999A;
  localparam logic [63:0] D_NEG_MILLI = 64'hBF50_624D_D2F1_A9FC;

  typedef logic [HU_ORDER-1:0][DBL_W-1:0] moment_set_t;

  // One result item as the block should report it.
  typedef struct {
    status_e           status;
    logic [CLS_W-1:0]  match_class;
    logic [DIST_W-1:0] match_distance;
    logic [HELD_W-1:0] templates_held;
  } verdict_t;

  // Keeps the verdicts that are still owed by the block, in order, and
  // compares every result item that it hands out against the oldest one.
  class verdict_board;
    verdict_t owed[$];
    int       fails;

    function void note_item(verdict_t v);
      owed.insert(owed.size(), v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (owed.size() == 0) begin
        $error("result item with no item outstanding: status %0d", got.status);
        fails++;
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.match_class !== want.match_class) begin
        $error("match_class: expected %0d, got %0d", want.match_class, got.match_class);
        fails++;
      end
      if (got.match_distance !== want.match_distance) begin
        $error("match_distance: expected %0d, got %0d",
               want.match_distance, got.match_distance);
        fails++;
      end
      if (got.templates_held !== want.templates_held) begin
        $error("templates_held: expected %0d, got %0d",
               want.templates_held, got.templates_held);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [KIND_W-1:0]    kind_i;
  logic [CLS_W-1:0]     class_id_i;
  logic [DBL_W-1:0]     hu_0_i, hu_1_i, hu_2_i, hu_3_i, hu_4_i, hu_5_i, hu_6_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STAT_W-1:0]    status_o;
  logic [CLS_W-1:0]     match_class_o;
  logic [DIST_W-1:0]    match_distance_o;
  logic [HELD_W-1:0]    templates_held_o;
  logic                 psel, penable, pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  hu_moment_nearest_template i_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .kind_i, .class_id_i,
    .hu_0_i, .hu_1_i, .hu_2_i, .hu_3_i, .hu_4_i, .hu_5_i, .hu_6_i,
    .out_valid_o, .out_stall_i,
    .status_o, .match_class_o, .match_distance_o, .templates_held_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  verdict_board board = new();

  // Shadow copy of the block's table and threshold, updated as each item is
  // taken. The threshold only moves while the block is idle.
  logic [CLS_W-1:0]        shadow_class [MAX_TEMPLATES];
  logic signed [LOG_W-1:0] shadow_log   [MAX_TEMPLATES][HU_ORDER];
  int unsigned             shadow_total;
  logic [DIST_W-1:0]       shadow_threshold;

  // Moment sets appended since the last clear; queries perturb these so that
  // matches actually happen and the threshold test is exercised both ways.
  moment_set_t stored_sets[$];

  bit quiet;           // when set, neither side idles or stalls
  bit clears_allowed;
  int cycle_count;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Signed log10 magnitude in fixed point. The log2 of the significand is
  // built bit by bit through repeated squaring, then scaled by log10(2),
  // rounded half away from zero and saturated.
  function automatic logic signed [LOG_W-1:0] log_magnitude(logic [63:0] bits);
    bit                 hneg;
    logic [10:0]        ex;
    longint unsigned    fr, y, f, mag, hi, lo, r;
    longint             e, v;
    bit                 lneg;
    longint             res;
    hneg = bits[63];
    ex   = bits[62:52];
    fr   = {12'd0, bits[51:0]};
    f    = 0;
    if (ex == 11'h7FF) begin
      if (fr != 0) return '0;
      return hneg ? -$signed(LOG_MAX) : $signed(LOG_MAX);
    end
    if (ex == 0) begin
      if (fr == 0) return '0;
      e = -1022;
      while (fr[52] == 1'b0) begin
        fr = fr << 1;
        e--;
      end
    end else begin
      fr[52] = 1'b1;
      e = longint'(ex) - 1023;
    end
    y = fr >> 21;
    for (int i = 0; i < 32; i++) begin
      y = (y * y) >> 31;
      f = f << 1;
      if (y >= 64'h1_0000_0000) begin
        f = f | 1;
        y = y >> 1;
      end
    end
    v = e * 64'sd4294967296 + longint'(f);
    lneg = v < 0;
    mag = lneg ? longint'(-v) : longint'(v);
    hi = mag >> 32;
    lo = mag & 64'hFFFF_FFFF;
    r = hi * LOG10_2_Q32 + ((lo * LOG10_2_Q32) >> 32);
    r = (r + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    if (r > LOG_MAX) r = LOG_MAX;
    res = longint'(r);
    if (hneg != lneg) res = -res;
    return LOG_W'(res);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Applies one accepted item to the shadow table and returns its verdict.
  function automatic verdict_t classify_item(logic [KIND_W-1:0] kind,
                                             logic [CLS_W-1:0] cls,
                                             moment_set_t hu);
    verdict_t                out;
    logic signed [LOG_W-1:0] q [HU_ORDER];
    longint unsigned         best, sum, mag, root, thr;
    longint                  d;
    for (int j = 0; j < HU_ORDER; j++) q[j] = log_magnitude(hu[j]);
    out.match_class    = '0;
    out.match_distance = '0;
    if (kind == KIND_CLEAR) begin
      shadow_total = 0;
      out.status = ST_CLEARED;
    end else if (kind == KIND_APPEND) begin
      if (shadow_total < MAX_TEMPLATES) begin
        shadow_class[shadow_total] = cls;
        for (int j = 0; j < HU_ORDER; j++) shadow_log[shadow_total][j] = q[j];
        shadow_total++;
        out.status = ST_APPENDED;
      end else begin
        out.status = ST_FULL;
      end
    end else if (shadow_total == 0) begin
      out.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int t = 0; t < shadow_total; t++) begin
        sum = 0;
        for (int j = 0; j < HU_ORDER; j++) begin
          d   = longint'(q[j]) - longint'(shadow_log[t][j]);
          mag = d < 0 ? longint'(-d) : longint'(d);
          sum += mag * mag;
        end
        // The earliest template wins a tie, so only a strict drop replaces it.
        if (t == 0 || sum < best) begin
          best = sum;
          out.match_class = shadow_class[t];
        end
      end
      root = floor_root(best);
      if (root > DIST_MAX) root = DIST_MAX;
      out.match_distance = DIST_W'(root);
      thr = shadow_threshold;
      out.status = (best > thr * thr) ? ST_UNKNOWN : ST_MATCHED;
    end
    out.templates_held = HELD_W'(shadow_total);
    return out;
  endfunction

  // Presents one item, holds it until the block takes it, and records what
  // the block should answer. Gaps in front of the item are random.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [CLS_W-1:0] cls,
                           moment_set_t hu);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    class_id_i <= cls;
    hu_0_i <= hu[0];
    hu_1_i <= hu[1];
    hu_2_i <= hu[2];
    hu_3_i <= hu[3];
    hu_4_i <= hu[4];
    hu_5_i <= hu[5];
    hu_6_i <= hu[6];
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(classify_item(kind, cls, hu));
    if (kind == KIND_CLEAR) stored_sets.delete();
    else if (kind == KIND_APPEND && stored_sets.size() < MAX_TEMPLATES)
      stored_sets.insert(stored_sets.size(), hu);
    @(negedge clk_i);
  endtask

  // Register write with a setup and an access phase. Only the threshold
  // address holds a register; the shadow copy follows that one alone.
  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == REG_THRESHOLD) shadow_threshold = value[DIST_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Parks the sender until every outstanding result has come back.
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
  endtask

  // Mostly moments in the range real shapes produce, with a share of raw bit
  // patterns, subnormals and special values mixed in.
  function automatic logic [63:0] random_moment();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)
      return {1'($urandom), 11'($urandom_range(1023, 990)), $urandom, 20'($urandom)};
    if (pick < 82) return {$urandom, $urandom};
    if (pick < 90) return {12'h000, 20'($urandom), $urandom};
    case ($urandom_range(5))
      0: return $urandom_range(1) ? D_POS_ZERO : D_NEG_ZERO;
      1: return $urandom_range(1) ? D_POS_INF : D_NEG_INF;
      2: return {1'($urandom), 11'h7FF, 20'($urandom) | 20'd1, $urandom};
      3: return D_MAX;
      4: return D_SUB_MIN;
      default: return D_ONE;
    endcase
  endfunction

  function automatic moment_set_t random_set();
    moment_set_t s;
    for (int j = 0; j < HU_ORDER; j++) s[j] = random_moment();
    return s;
  endfunction

  // A query near a held template: some moments get their low mantissa bits
  // disturbed, which moves the log value by anything from nothing to a lot.
  function automatic moment_set_t nearby_set();
    moment_set_t s;
    s = stored_sets[$urandom_range(stored_sets.size() - 1)];
    for (int j = 0; j < HU_ORDER; j++)
      if ($urandom_range(1))
        s[j] = s[j] ^ (64'($urandom) >> $urandom_range(63, 12));
    return s;
  endfunction

  task automatic random_phase(int count, bit fill_first);
    int unsigned pick;
    logic [KIND_W-1:0] kind;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (clears_allowed && pick < 4)            kind = KIND_CLEAR;
      else if (pick < (fill_first ? 60 : 42))    kind = KIND_APPEND;
      else if (pick < 97)                        kind = KIND_QUERY;
      else                                       kind = KIND_SPARE;
      if (kind != KIND_APPEND && kind != KIND_CLEAR && stored_sets.size() != 0 &&
          $urandom_range(99) < 75)
        send_item(kind, 16'($urandom), nearby_set());
      else
        send_item(kind, 16'($urandom), random_set());
    end
  endtask

  // Receiver side: random stalls, none at all while the quiet stretch runs.
  always @(negedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk_i) begin
    verdict_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status         = status_e'(status_o);
      got.match_class    = match_class_o;
      got.match_distance = match_distance_o;
      got.templates_held = templates_held_o;
      board.check_result(got);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** hu_moment_nearest_template: FAILED **");
      $finish;
    end
  end

  initial begin
    moment_set_t edge_a, edge_b;
    clk_i       = 1'b0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    kind_i      = KIND_CLEAR;
    class_id_i  = '0;
    {hu_0_i, hu_1_i, hu_2_i, hu_3_i, hu_4_i, hu_5_i, hu_6_i} = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    shadow_total     = 0;
    shadow_threshold = THR_RESET;
    quiet            = 1'b0;
    clears_allowed   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. Signed zeros, units, infinities and a NaN in one set;
    // the largest double, both subnormal extremes, the smallest negative
    // normal and two ordinary fractions in the other.
    edge_a = {D_NAN, D_NEG_INF, D_POS_INF, D_NEG_ONE, D_ONE, D_NEG_ZERO, D_POS_ZERO};
    edge_b = {D_NEG_MILLI, D_TENTH, D_NEG_NORM, D_SUB_MAX, D_SUB_MIN, D_MAX, D_TENTH};
    send_item(KIND_QUERY, 16'h0000, edge_a);   // query against an empty table
    send_item(KIND_CLEAR, 16'hFFFF, edge_b);
    send_item(KIND_APPEND, 16'h0000, edge_a);
    send_item(KIND_APPEND, 16'hFFFF, edge_b);
    send_item(KIND_QUERY, 16'h1234, edge_a);   // exact hit on the first template
    send_item(KIND_QUERY, 16'h1234, edge_b);
    send_item(KIND_SPARE, 16'hABCD, edge_b);   // unused kind behaves as a query
    send_item(KIND_APPEND, 16'h0000, edge_a);  // duplicate: earlier entry wins ties
    send_item(KIND_QUERY, 16'h0000, edge_a);
    send_item(KIND_QUERY, 16'h0000, {HU_ORDER{D_NEG_INF}});
    send_item(KIND_QUERY, 16'h0000, {HU_ORDER{D_POS_INF}});
    send_item(KIND_CLEAR, 16'h0000, edge_a);
    send_item(KIND_QUERY, 16'h0000, edge_b);   // empty again after the clear

    // Phase with the reset threshold and no clears, so the table fills up and
    // appends start coming back full.
    random_phase(140, 1'b1);
    for (int n = 0; n < 4; n++) send_item(KIND_APPEND, 16'($urandom), random_set());
    wait_for_idle();

    // Threshold at zero: only exact hits match. The write to the empty
    // address must leave the threshold alone.
    write_register(REG_THRESHOLD, 32'd0);
    write_register(REG_NONE, 32'hFFFF_FFFF);
    clears_allowed = 1'b1;
    random_phase(110, 1'b0);
    wait_for_idle();

    // Largest threshold, run with neither side idling.
    write_register(REG_THRESHOLD, 32'(DIST_MAX));
    quiet = 1'b1;
    random_phase(110, 1'b0);
    wait_for_idle();
    quiet = 1'b0;

    // A threshold of one unit in the log domain and then a random one.
    write_register(REG_THRESHOLD, 32'd65536);
    random_phase(120, 1'b0);
    wait_for_idle();
    write_register(REG_THRESHOLD, 32'($urandom_range(DIST_MAX)));
    random_phase(120, 1'b0);
    wait_for_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fails == 0 && board.owed.size() == 0) begin
      $display("** hu_moment_nearest_template: PASSED **");
    end else begin
      $display("** hu_moment_nearest_template: FAILED **");
    end
    $finish;
  end

endmodule
